FILE: rtl/pla_pkg.sv
// ----------------------------------------------------------------------------
// pla_pkg
// Shared types, widths and log2/exp2 tables of the Phong light accumulator.
// ----------------------------------------------------------------------------
package pla_pkg;

  localparam int LOG_TABLE_BITS = 8;
  localparam int EXP_TABLE_BITS = 8;
  localparam int LOG_SIZE = 1 << LOG_TABLE_BITS;
  localparam int EXP_SIZE = 1 << EXP_TABLE_BITS;

  localparam int DOT_W = 18;   // clamped dot product, Q4.14
  localparam int LG_W  = 22;   // signed log2, Q.16
  localparam int Y_W   = 31;   // signed ns*log2, Q.16
  localparam int P_W   = 26;   // power, Q.14
  localparam logic [P_W-1:0] PCAP = '1;
  localparam logic [P_W-1:0] P_ONE = P_W'(16384);

  typedef struct packed {
    logic        do_diff;
    logic        do_spec;
    logic        last;
    logic [23:0] object_color;
    logic [47:0] light_color;
    logic [47:0] normal_vec;
    logic [47:0] light_dir;
    logic [47:0] reflect_dir;
    logic [15:0] diffuse_coef;
    logic [15:0] specular_coef;
    logic [15:0] shininess;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [DOT_W-1:0] x;
    logic [15:0]      ns;
  } pow_req_t;

  typedef struct packed {
    logic           done;
    logic [P_W-1:0] p;
  } pow_rsp_t;

  typedef logic [15:0] log_rom_t [LOG_SIZE];
  typedef logic [31:0] exp_rom_t [EXP_SIZE];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v   = v_in;
    res = '0;
    bt  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bt > v) bt = bt >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bt != 0) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  function automatic log_rom_t build_log_rom();
    log_rom_t    rom;
    logic [63:0] m;
    logic [15:0] acc;
    for (int i = 0; i < LOG_SIZE; i++) begin
      m   = (64'(LOG_SIZE) + 64'(i)) << (30 - LOG_TABLE_BITS);
      acc = '0;
      for (int k = 0; k < 16; k++) begin
        m   = (m * m) >> 30;
        acc = {acc[14:0], 1'b0};
        if (m >= 64'h8000_0000) begin
          acc[0] = 1'b1;
          m = m >> 1;
        end
      end
      rom[i] = acc;
    end
    return rom;
  endfunction

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] roots [EXP_TABLE_BITS+1];
    logic [63:0] e;
    roots[0] = 64'h8000_0000;
    for (int k = 1; k <= EXP_TABLE_BITS; k++) roots[k] = isqrt64(roots[k-1] << 30);
    for (int i = 0; i < EXP_SIZE; i++) begin
      e = 64'h4000_0000;
      for (int b = EXP_TABLE_BITS - 1; b >= 0; b--) begin
        if (((i >> b) & 1) != 0) e = (e * roots[EXP_TABLE_BITS-b]) >> 30;
      end
      rom[i] = e[31:0];
    end
    return rom;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();
  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

FILE: rtl/pla_front.sv
// ----------------------------------------------------------------------------
// pla_front
// Input side: takes items, decodes the mode and holds them in a 2-entry queue.
// ----------------------------------------------------------------------------
module pla_front import pla_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [23:0] object_color,
  input  logic [47:0] light_color,
  input  logic [47:0] normal_vec,
  input  logic [47:0] light_dir,
  input  logic [47:0] reflect_dir,
  input  logic [15:0] diffuse_coef,
  input  logic [15:0] specular_coef,
  input  logic [15:0] shininess,
  input  logic        last,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  localparam logic [1:0] MODE_DIFF = 2'd0;
  localparam logic [1:0] MODE_SPEC = 2'd1;
  localparam logic [1:0] MODE_BOTH = 2'd2;

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      item_in;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rd_ptr];

  always_comb begin
    item_in.do_diff       = (mode == MODE_DIFF) || (mode == MODE_BOTH);
    item_in.do_spec       = (mode == MODE_SPEC) || (mode == MODE_BOTH);
    item_in.last          = last;
    item_in.object_color  = object_color;
    item_in.light_color   = light_color;
    item_in.normal_vec    = normal_vec;
    item_in.light_dir     = light_dir;
    item_in.reflect_dir   = reflect_dir;
    item_in.diffuse_coef  = diffuse_coef;
    item_in.specular_coef = specular_coef;
    item_in.shininess     = shininess;
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: rtl/pla_pow.sv
// ----------------------------------------------------------------------------
// pla_pow
// Three-stage x^ns unit: log2 lookup, scale by ns, exp2 lookup and shift.
// ----------------------------------------------------------------------------
module pla_pow import pla_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  pow_req_t req,
  output pow_rsp_t rsp
);

  logic                    v1, v2, v3;
  logic signed [LG_W-1:0]  lg;
  logic signed [Y_W-1:0]   y;
  logic [15:0]             ns1, ns2;
  logic                    zero1, zero2;
  logic [P_W-1:0]          p_out;

  logic [4:0]              msb;
  logic [DOT_W-1:0]        xn;
  logic signed [5:0]       pe;
  logic signed [LG_W-1:0]  lg_next;
  logic signed [LG_W+16:0] prod;
  logic signed [Y_W-17:0]  n;
  logic [31:0]             e;
  logic signed [Y_W-15:0]  sh;
  logic [31:0]             e_sh;
  logic [P_W-1:0]          p_next;

  always_comb begin
    msb = '0;
    for (int i = 0; i < DOT_W; i++) begin
      if (req.x[i]) msb = 5'(i);
    end
    xn      = req.x << (5'(DOT_W - 1) - msb);
    pe      = $signed({1'b0, msb}) - 6'sd14;
    lg_next = $signed({pe, 16'b0}) +
              $signed({6'b0, LOG_ROM[xn[DOT_W-2 -: LOG_TABLE_BITS]]});
  end

  assign prod = $signed({1'b0, ns1}) * lg;

  always_comb begin
    n    = y[Y_W-1:16];
    e    = EXP_ROM[y[15 -: EXP_TABLE_BITS]];
    sh   = (Y_W-15)'(16) - (Y_W-15)'(n);
    e_sh = (sh >= 32) ? '0 : (e >> sh[4:0]);
    priority if (zero2) begin
      p_next = (ns2 == 16'd0) ? P_ONE : '0;
    end else if (n >= 12) begin
      p_next = PCAP;
    end else if (n < -47) begin
      p_next = '0;
    end else if (e_sh > 32'(PCAP)) begin
      p_next = PCAP;
    end else begin
      p_next = e_sh[P_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    lg    <= lg_next;
    ns1   <= req.ns;
    zero1 <= (req.x == '0);
    y     <= prod[LG_W+16:8];
    ns2   <= ns1;
    zero2 <= zero1;
    p_out <= p_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= req.start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign rsp.done = v3;
  assign rsp.p    = p_out;

endmodule

FILE: rtl/pla_back.sv
// ----------------------------------------------------------------------------
// pla_back
// Execution side: dot products, per-channel terms, saturating accumulation
// and the output register.
// ----------------------------------------------------------------------------
module pla_back import pla_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  item_t    q_item,
  output logic     q_pop,
  output pow_req_t pow_req,
  input  pow_rsp_t pow_rsp,
  output logic     out_valid,
  input  logic     out_ready,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DOT   = 4'd1;
  localparam logic [3:0] ST_CLAMP = 4'd2;
  localparam logic [3:0] ST_KD    = 4'd3;
  localparam logic [3:0] ST_POW   = 4'd4;
  localparam logic [3:0] ST_M1    = 4'd5;
  localparam logic [3:0] ST_M2    = 4'd6;
  localparam logic [3:0] ST_DIVA  = 4'd7;
  localparam logic [3:0] ST_DIVB  = 4'd8;
  localparam logic [3:0] ST_ADDD  = 4'd9;
  localparam logic [3:0] ST_ADDS  = 4'd10;
  localparam logic [3:0] ST_FIN   = 4'd11;

  function automatic logic [15:0] lane16(input logic [47:0] v, input logic [1:0] idx);
    logic [15:0] r;
    case (idx)
      2'd0:    r = v[47:32];
      2'd1:    r = v[31:16];
      default: r = v[15:0];
    endcase
    return r;
  endfunction

  function automatic logic [7:0] byte8(input logic [23:0] v, input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = v[23:16];
      2'd1:    r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

  function automatic logic [7:0] to_byte(input logic [31:0] a);
    logic [39:0] v;
    v = {a, 8'b0} - {8'b0, a};
    return (v[39:16] > 24'd255) ? 8'd255 : v[23:16];
  endfunction

  logic [3:0]         state;
  logic [1:0]         lane;
  logic [1:0]         chan;
  item_t              cur;
  logic signed [33:0] nsum, ssum;
  logic [DOT_W-1:0]   ddot, sdot;
  logic [19:0]        kval;
  logic [P_W-1:0]     pval;
  logic [27:0]        dm1;
  logic [31:0]        sm1;
  logic [43:0]        dm2;
  logic [33:0]        sm2;
  logic [26:0]        dq;
  logic [19:0]        dr;
  logic [31:0]        acc [3];
  logic [7:0]         red_q, green_q, blue_q;
  logic               out_load;

  logic signed [15:0] na, la, ra;
  logic signed [31:0] np, sp;
  logic [33:0]        kd_prod;
  logic [33:0]        dx;
  logic [26:0]        r0;
  logic [25:0]        q0;
  logic [26:0]        q1;
  logic [19:0]        r1;
  logic [12:0]        r2;
  logic [26:0]        q2;
  logic [8:0]         r3;
  logic [26:0]        q3;
  logic [33:0]        add_val;
  logic [34:0]        sum;

  always_comb begin
    na = $signed(lane16(cur.normal_vec, lane));
    la = $signed(lane16(cur.light_dir, lane));
    ra = $signed(lane16(cur.reflect_dir, lane));
    np = na * la;
    sp = ra * la;
    kd_prod = cur.diffuse_coef * ddot;
    dx = dm2[43:10];
    q0 = dx[33:8];
    r0 = 27'(dx[33:8]) + 27'(dx[7:0]);
    q1 = 27'(q0) + 27'(r0[26:8]);
    r1 = 20'(r0[26:8]) + 20'(r0[7:0]);
    r2 = 13'(dr[19:8]) + 13'(dr[7:0]);
    q2 = dq + 27'(dr[19:8]);
    r3 = 9'(r2[12:8]) + 9'(r2[7:0]);
    q3 = q2 + 27'(r2[12:8]) + 27'(r3 >= 9'd255);
    add_val = (state == ST_ADDD) ? (cur.do_diff ? 34'(dq) : '0)
                                 : (cur.do_spec ? sm2 : '0);
    sum = 35'(acc[chan]) + 35'(add_val);
  end

  assign q_pop       = (state == ST_IDLE) && q_valid;
  assign out_load    = (state == ST_FIN) && cur.last && (!out_valid || out_ready);
  assign pow_req.start = (state == ST_KD);
  assign pow_req.x     = sdot;
  assign pow_req.ns    = cur.shininess;

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_item;
    unique case (state)
      ST_IDLE: begin
        nsum <= '0;
        ssum <= '0;
      end
      ST_DOT: begin
        nsum <= nsum + 34'(np);
        ssum <= ssum + 34'(sp);
      end
      ST_CLAMP: begin
        ddot <= (nsum > 0) ? nsum[31:14] : '0;
        sdot <= (ssum > 0) ? ssum[31:14] : '0;
      end
      ST_KD:   kval <= kd_prod[33:14];
      ST_POW:  pval <= pow_rsp.p;
      ST_M1: begin
        dm1 <= kval * byte8(cur.object_color, chan);
        sm1 <= cur.specular_coef * lane16(cur.light_color, chan);
      end
      ST_M2: begin
        dm2 <= dm1 * lane16(cur.light_color, chan);
        sm2 <= 34'((58'(sm1) * 58'(pval)) >> 24);
      end
      ST_DIVA: begin
        dq <= q1;
        dr <= r1;
      end
      ST_DIVB: dq <= q3;
      default: ;
    endcase
    if (out_load) begin
      red_q   <= to_byte(acc[0]);
      green_q <= to_byte(acc[1]);
      blue_q  <= to_byte(acc[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lane      <= '0;
      chan      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) acc[i] <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          lane <= '0;
          if (q_valid) state <= ST_DOT;
        end
        ST_DOT: begin
          lane <= lane + 2'd1;
          if (lane == 2'd2) state <= ST_CLAMP;
        end
        ST_CLAMP: state <= ST_KD;
        ST_KD:    state <= ST_POW;
        ST_POW: begin
          chan <= '0;
          if (pow_rsp.done) state <= ST_M1;
        end
        ST_M1:   state <= ST_M2;
        ST_M2:   state <= ST_DIVA;
        ST_DIVA: state <= ST_DIVB;
        ST_DIVB: state <= ST_ADDD;
        ST_ADDD, ST_ADDS: begin
          acc[chan] <= (sum[34:32] != 3'd0) ? '1 : sum[31:0];
          if (state == ST_ADDD) begin
            state <= ST_ADDS;
          end else if (chan == 2'd2) begin
            state <= ST_FIN;
          end else begin
            chan  <= chan + 2'd1;
            state <= ST_M1;
          end
        end
        ST_FIN: begin
          if (!cur.last) begin
            state <= ST_IDLE;
          end else if (out_load) begin
            for (int i = 0; i < 3; i++) acc[i] <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign red   = red_q;
  assign green = green_q;
  assign blue  = blue_q;

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == ST_IDLE) else $error("queue pop outside idle");

  a_pow_wait: assert property (@(posedge clk) disable iff (rst)
    pow_rsp.done |-> state == ST_POW) else $error("power result while not waiting");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (acc[0] == '0 && acc[1] == '0 && acc[2] == '0 && out_valid))
    else $error("accumulators not cleared after result");

endmodule

FILE: rtl/phong_light_accumulator.sv
// ----------------------------------------------------------------------------
// phong_light_accumulator
// Accumulates diffuse and specular Phong terms per light, emits RGB on last.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    mode .. last (one light term)
// out      output     out_valid/out_ready  red, green, blue
//
// The back end handles one item at a time, stepping three dot lanes, a three-stage
// power unit and six states for each color channel on one datapath.
// The front queue holds two items, so input transfers continue while the
// back end works or a result waits in the output register.
// rst is synchronous and clears the queue, sequencer and accumulators.
// ----------------------------------------------------------------------------
module phong_light_accumulator import pla_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [23:0] object_color,
  input  logic [47:0] light_color,
  input  logic [47:0] normal_vec,
  input  logic [47:0] light_dir,
  input  logic [47:0] reflect_dir,
  input  logic [15:0] diffuse_coef,
  input  logic [15:0] specular_coef,
  input  logic [15:0] shininess,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  logic     q_valid;
  item_t    q_item;
  logic     q_pop;
  pow_req_t pow_req;
  pow_rsp_t pow_rsp;

  pla_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .object_color(object_color), .light_color(light_color),
    .normal_vec(normal_vec), .light_dir(light_dir), .reflect_dir(reflect_dir),
    .diffuse_coef(diffuse_coef), .specular_coef(specular_coef),
    .shininess(shininess), .last(last),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  pla_pow u_pow (
    .clk(clk), .rst(rst), .req(pow_req), .rsp(pow_rsp)
  );

  pla_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .pow_req(pow_req), .pow_rsp(pow_rsp),
    .out_valid(out_valid), .out_ready(out_ready),
    .red(red), .green(green), .blue(blue)
  );

endmodule

FILE: dv/tb_phong_light_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_phong_light_accumulator
// Drives light terms into the Phong accumulator and checks each emitted RGB
// transfer against an in-bench fixed-point shading model, under idle patterns
// on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_phong_light_accumulator;
  import pla_pkg::*;

  localparam logic [1:0] MODE_DIFF = 2'd0;
  localparam logic [1:0] MODE_SPEC = 2'd1;
  localparam logic [1:0] MODE_BOTH = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int LB = 8;
  localparam int EB = 8;

  typedef struct {
    logic [1:0]  md;
    logic [23:0] obj;
    logic [47:0] lc, nv, ld, rd;
    logic [15:0] kd, ks, ns;
    logic        lst;
  } term_t;

  typedef struct {
    logic [7:0] r, g, b;
  } rgb_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] mode = '0;
  logic [23:0] object_color = '0;
  logic [47:0] light_color = '0, normal_vec = '0, light_dir = '0, reflect_dir = '0;
  logic [15:0] diffuse_coef = '0, specular_coef = '0, shininess = '0;
  logic last = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [7:0] red, green, blue;

  phong_light_accumulator u_dut (.*);

  initial forever #5 clk = ~clk;

  logic [15:0] lg_tab [1<<LB];
  logic [31:0] ex_tab [1<<EB];
  logic [31:0] acc_r, acc_g, acc_b;
  rgb_t pixel_q [$];
  int err_cnt = 0;
  int pix_cnt = 0;
  int term_cnt = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_off = 0;

  function automatic logic [63:0] sq_root(logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'h4000_0000_0000_0000;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  task automatic make_tables();
    logic [63:0] m, e;
    logic [63:0] rt [EB+1];
    logic [15:0] a;
    for (int i = 0; i < (1<<LB); i++) begin
      m = (64'(1<<LB) + 64'(i)) << (30 - LB);
      a = 0;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        a = a << 1;
        if (m >= 64'h8000_0000) begin
          a[0] = 1;
          m = m >> 1;
        end
      end
      lg_tab[i] = a;
    end
    rt[0] = 64'h8000_0000;
    for (int k = 1; k <= EB; k++) rt[k] = sq_root(rt[k-1] << 30);
    for (int i = 0; i < (1<<EB); i++) begin
      e = 64'h4000_0000;
      for (int b = EB - 1; b >= 0; b--)
        if ((i >> b) & 1) e = (e * rt[EB-b]) >> 30;
      ex_tab[i] = e[31:0];
    end
  endtask

  function automatic longint clamp_dot(logic [47:0] a, logic [47:0] b);
    longint s;
    s = 0;
    for (int i = 0; i < 3; i++)
      s += longint'($signed(a[32-16*i +: 16])) * longint'($signed(b[32-16*i +: 16]));
    return (s <= 0) ? 0 : (s >>> 14);
  endfunction

  function automatic longint floor_div(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint spec_power(longint x, longint ns);
    int p;
    int idx;
    longint lg, y, n, f, e;
    if (x == 0) return (ns == 0) ? 16384 : 0;
    p = 0;
    for (int i = 0; i < 40; i++) if ((x >> i) & 1) p = i;
    idx = (p >= LB) ? int'(x >> (p - LB)) : int'(x << (LB - p));
    idx = idx & ((1<<LB) - 1);
    lg = (longint'(p) - 14) * 65536 + longint'(lg_tab[idx]);
    y = floor_div(ns * lg, 8);
    n = floor_div(y, 16);
    f = y - n * 65536;
    e = longint'(ex_tab[(f >> (16 - EB)) & ((1<<EB) - 1)]);
    if (n >= 12) return (64'd1 << 26) - 1;
    if (16 - n > 63) return 0;
    e = e >> (16 - n);
    return (e > (64'd1 << 26) - 1) ? (64'd1 << 26) - 1 : e;
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [63:0] v);
    logic [64:0] s;
    s = 65'(a) + 65'(v);
    return (s > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [7:0] to_byte(logic [31:0] a);
    logic [63:0] v;
    v = (64'(a) * 255) >> 16;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  task automatic shade_term(term_t t);
    logic [63:0] k, pw, add [3];
    rgb_t px;
    add = '{0, 0, 0};
    if (t.md == MODE_DIFF || t.md == MODE_BOTH) begin
      k = (64'(t.kd) * 64'(clamp_dot(t.nv, t.ld))) >> 14;
      for (int c = 0; c < 3; c++)
        add[c] = (k * 64'(t.obj[16-8*c +: 8]) * 64'(t.lc[32-16*c +: 16])) / (255 * 1024);
      acc_r = sat_add(acc_r, add[0]);
      acc_g = sat_add(acc_g, add[1]);
      acc_b = sat_add(acc_b, add[2]);
    end
    if (t.md == MODE_SPEC || t.md == MODE_BOTH) begin
      pw = 64'(spec_power(clamp_dot(t.rd, t.ld), longint'(t.ns)));
      for (int c = 0; c < 3; c++)
        add[c] = (64'(t.ks) * pw * 64'(t.lc[32-16*c +: 16])) >> 24;
      acc_r = sat_add(acc_r, add[0]);
      acc_g = sat_add(acc_g, add[1]);
      acc_b = sat_add(acc_b, add[2]);
    end
    if (t.lst) begin
      px.r = to_byte(acc_r);
      px.g = to_byte(acc_g);
      px.b = to_byte(acc_b);
      pixel_q.push_back(px);
      acc_r = 0;
      acc_g = 0;
      acc_b = 0;
    end
  endtask

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    err_cnt++;
  endtask

  task automatic send_term(term_t t);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    mode <= t.md;
    object_color <= t.obj;
    light_color <= t.lc;
    normal_vec <= t.nv;
    light_dir <= t.ld;
    reflect_dir <= t.rd;
    diffuse_coef <= t.kd;
    specular_coef <= t.ks;
    shininess <= t.ns;
    last <= t.lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shade_term(t);
    term_cnt++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("unexpected transfer, red", red, 8'd0);
        end else begin
          rgb_t w;
          w = pixel_q.pop_front();
          if (red !== w.r) report_mismatch("red", red, w.r);
          if (green !== w.g) report_mismatch("green", green, w.g);
          if (blue !== w.b) report_mismatch("blue", blue, w.b);
          pix_cnt++;
        end
      end
      out_ready <= !hold_off && !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end
  end

  function automatic logic [47:0] rand_vec(bit unit_like);
    logic [47:0] v;
    for (int i = 0; i < 3; i++)
      v[16*i +: 16] = unit_like ? 16'($signed($urandom_range(32768)) - 16384)
                                : 16'($urandom);
    return v;
  endfunction

  function automatic term_t rand_term(bit lst);
    term_t t;
    bit ok;
    ok = $urandom_range(9) < 8;
    t.md = ok ? 2'($urandom_range(2)) : 2'($urandom);
    t.obj = 24'($urandom);
    t.lc = ok ? {4'h0, 12'($urandom), 4'h0, 12'($urandom), 4'h0, 12'($urandom)}
              : {16'($urandom), 32'($urandom)};
    if ($urandom_range(3) == 0) t.lc = {16'($urandom), 32'($urandom)};
    t.nv = rand_vec(ok);
    t.ld = rand_vec(ok);
    t.rd = rand_vec(ok);
    t.kd = ok ? 16'($urandom_range(16384)) : 16'($urandom);
    t.ks = ok ? 16'($urandom_range(16384)) : 16'($urandom);
    t.ns = ok ? 16'($urandom_range(128 * 256)) : 16'($urandom);
    t.lst = lst;
    return t;
  endfunction

  task automatic test_directed();
    term_t t;
    t = '{MODE_DIFF, 24'hFFFFFF, {3{16'h1000}}, {16'h0, 16'h0, 16'h4000},
          {16'h0, 16'h0, 16'h4000}, {16'h0, 16'h0, 16'h4000}, 16'h4000, 16'h4000,
          16'h0A00, 1'b1};
    send_term(t);
    t.md = MODE_SPEC; send_term(t);
    t.md = MODE_BOTH; send_term(t);
    t.md = MODE_NONE; send_term(t);
    t.md = MODE_SPEC; t.rd = {16'h0, 16'h0, 16'hC000}; t.ns = 0; send_term(t);
    t.ns = 16'h0100; send_term(t);
    t.md = MODE_BOTH; t.lc = '1; t.obj = '1; t.kd = '1; t.ks = '1; t.ns = '1;
    t.nv = {3{16'h8000}}; t.ld = {3{16'h8000}}; t.rd = {3{16'h8000}}; t.lst = 0;
    for (int i = 0; i < 4; i++) send_term(t);
    t.lst = 1; send_term(t);
    t.nv = {3{16'h7FFF}}; t.ld = {3{16'h7FFF}}; t.rd = {3{16'h7FFF}}; t.ns = 1;
    send_term(t);
    t.ns = 16'h0001; t.rd = {16'h0, 16'h0, 16'h0001}; t.ld = {16'h0, 16'h0, 16'h4000};
    t.md = MODE_SPEC; send_term(t);
    t.md = MODE_DIFF; t.nv = '0; send_term(t);
    t.lst = 0; t.md = MODE_NONE; send_term(t);
    t.lst = 1; t.obj = '0; t.lc = '0; send_term(t);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_term(rand_term($urandom_range(3) == 0));
    send_term(rand_term(1));
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int i = 0; i < 30; i++) send_term(rand_term($urandom_range(1)));
        in_valid <= 0;
        @(posedge clk);
      end
    join
    send_term(rand_term(1));
  endtask

  initial begin
    make_tables();
    acc_r = 0; acc_g = 0; acc_b = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    send_idle = 21; recv_idle = 84;
    test_random(320);
    send_idle = 84; recv_idle = 21;
    test_random(320);
    send_idle = 0; recv_idle = 0;
    test_backpressure();
    test_random(320);
    in_valid <= 0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d light terms and %0d pixel transfers", term_cnt, pix_cnt);
    if (err_cnt == 0) $display("tb_phong_light_accumulator: clean");
    else $display("tb_phong_light_accumulator: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("tb_phong_light_accumulator: errors");
    $finish;
  end
endmodule
